[hw/rtl/topkv_pkg.sv]
// package: shared types and constants of the top-k similarity vote block
`default_nettype none
package topkv_pkg;

   localparam int MAX_NEIGHBOURS_DEF = 8;
   localparam int IDENTITY_BITS_DEF  = 16;

   localparam int SCORE_BITS     = 16;
   localparam int FIELD_ID_BITS  = 16;
   localparam int BALLOT_BITS    = 4;
   localparam int NCOUNT_BITS    = 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_THRESHOLD  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NEIGHBOURS = 2'd1;

   // reset values: threshold is 0.6 in q1.15, rounded to nearest
   localparam logic signed [SCORE_BITS-1:0] THRESHOLD_RESET = 16'sd19661;
   localparam logic [NCOUNT_BITS-1:0]       NEIGHBOUR_RESET = 4'd3;

   typedef struct packed {
      logic [FIELD_ID_BITS-1:0]     identity;
      logic signed [SCORE_BITS-1:0] score;
      logic                         final_item;
   } req_item_type;

   typedef struct packed {
      logic                     found;
      logic [FIELD_ID_BITS-1:0] winner;
      logic [BALLOT_BITS-1:0]   ballots;
   } rsp_item_type;

   // per-cycle command to every cell of the chain
   typedef struct packed {
      logic insert;
      logic start;
      logic rotate;
      logic clear;
   } cell_ctl_type;

endpackage
`default_nettype wire

[hw/rtl/topkv_cell.sv]
// module: one cell of the ranked chain, holds one kept entry
`default_nettype none
module topkv_cell #(
   parameter int INDEX   = 0,
   parameter int ID_W    = topkv_pkg::IDENTITY_BITS_DEF,
   parameter int CNT_W   = 4
) (
   input  wire                                       clock,
   input  wire                                       reset,
   input  topkv_pkg::cell_ctl_type                   ctl,
   input  wire [CNT_W-1:0]                           vote_limit,
   input  wire [ID_W-1:0]                            new_id,
   input  wire signed [topkv_pkg::SCORE_BITS-1:0]    new_score,
   input  wire                                       prev_take,
   input  wire                                       prev_valid,
   input  wire [ID_W-1:0]                            prev_id,
   input  wire signed [topkv_pkg::SCORE_BITS-1:0]    prev_score,
   input  wire                                       next_valid,
   input  wire [ID_W-1:0]                            next_id,
   input  wire signed [topkv_pkg::SCORE_BITS-1:0]    next_score,
   input  wire                                       next_member,
   input  wire                                       next_pending,
   output logic                                      take,
   output logic                                      valid,
   output logic [ID_W-1:0]                           id,
   output logic signed [topkv_pkg::SCORE_BITS-1:0]   score,
   output logic                                      member,
   output logic                                      pending
);

   logic                                     valid_ff, valid_in;
   logic                                     member_ff, member_in;
   logic                                     pending_ff, pending_in;
   logic [ID_W-1:0]                          id_ff, id_in;
   logic signed [topkv_pkg::SCORE_BITS-1:0]  score_ff, score_in;
   logic                                     in_range;

   // strict compare: an equal score goes behind the kept one
   assign take     = ctl.insert & (~valid_ff | (new_score > score_ff));
   assign in_range = CNT_W'(INDEX) < vote_limit;

   always_comb begin
      valid_in   = valid_ff;
      member_in  = member_ff;
      pending_in = pending_ff;
      id_in      = id_ff;
      score_in   = score_ff;
      priority if (ctl.clear) begin
         valid_in   = 1'b0;
         member_in  = 1'b0;
         pending_in = 1'b0;
      end else if (ctl.start) begin
         member_in  = valid_ff & in_range;
         pending_in = valid_ff & in_range;
      end else if (ctl.rotate) begin
         valid_in   = next_valid;
         member_in  = next_member;
         pending_in = next_pending;
         id_in      = next_id;
         score_in   = next_score;
      end else if (prev_take) begin
         valid_in = prev_valid;
         id_in    = prev_id;
         score_in = prev_score;
      end else if (take) begin
         valid_in = 1'b1;
         id_in    = new_id;
         score_in = new_score;
      end else begin
         // hold the kept entry
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         member_ff  <= 1'b0;
         pending_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         member_ff  <= member_in;
         pending_ff <= pending_in;
      end
      id_ff    <= id_in;
      score_ff <= score_in;
   end

   assign valid   = valid_ff;
   assign id      = id_ff;
   assign score   = score_ff;
   assign member  = member_ff;
   assign pending = pending_ff;

endmodule
`default_nettype wire

[hw/rtl/topkv_tally.sv]
// module: vote counter and running best identity
`default_nettype none
module topkv_tally #(
   parameter int MAX_NEIGHBOURS = topkv_pkg::MAX_NEIGHBOURS_DEF,
   parameter int ID_W           = topkv_pkg::IDENTITY_BITS_DEF,
   parameter int CNT_W          = 4
) (
   input  wire                       clock,
   input  wire                       clear,
   input  wire                       step,
   input  wire [ID_W-1:0]            cand_id,
   input  wire [MAX_NEIGHBOURS-1:0]  member,
   input  wire [ID_W-1:0]            ids [MAX_NEIGHBOURS],
   output logic [ID_W-1:0]           best_id,
   output logic [CNT_W-1:0]          best_votes
);

   logic [ID_W-1:0]  best_id_ff, best_id_in;
   logic [CNT_W-1:0] best_votes_ff, best_votes_in;
   logic [CNT_W-1:0] votes;

   // votes of the candidate among all voting entries
   always_comb begin
      votes = '0;
      for (int i = 0; i < MAX_NEIGHBOURS; i++) begin
         votes = votes + CNT_W'(member[i] && (ids[i] == cand_id));
      end
   end

   // strict greater: the first identity in score order keeps a tie
   always_comb begin
      best_id_in    = best_id_ff;
      best_votes_in = best_votes_ff;
      priority if (clear) begin
         best_id_in    = '0;
         best_votes_in = '0;
      end else if (step && (votes > best_votes_ff)) begin
         best_id_in    = cand_id;
         best_votes_in = votes;
      end else begin
         // keep the running best
      end
   end

   always_ff @(posedge clock) begin
      best_id_ff    <= best_id_in;
      best_votes_ff <= best_votes_in;
   end

   assign best_id    = best_id_ff;
   assign best_votes = best_votes_ff;

endmodule
`default_nettype wire

[hw/rtl/topk_similarity_vote_top.sv]
// top level: insertion chain of ranked cells with majority vote on the last item
// after a final item the sequencer runs start, vote and emit; the vote is skipped if nothing is found
// throughput: one non-final item per cycle; after a final item, input is stalled until the result is loaded
// the vote steps once per voting entry through the chain rotation and the tally unit
// reset: synchronous active high; empties the chain, threshold 0.6, neighbour count 3
// kept entries need no clearing pass, only the per-cell valid, member and pending bits are reset
`default_nettype none
module topk_similarity_vote_top #(
   parameter int MAX_NEIGHBOURS = topkv_pkg::MAX_NEIGHBOURS_DEF,
   parameter int IDENTITY_BITS  = topkv_pkg::IDENTITY_BITS_DEF
) (
   input  wire                                    clock,
   input  wire                                    reset,
   // input items
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  topkv_pkg::req_item_type                req_item,
   // result items
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output topkv_pkg::rsp_item_type                rsp_item,
   // configuration writes
   input  wire                                    csr_write,
   input  wire [topkv_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire [topkv_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int CNT_W = $clog2(MAX_NEIGHBOURS + 1);
   localparam int LIM_W = (CNT_W > topkv_pkg::NCOUNT_BITS) ? CNT_W : topkv_pkg::NCOUNT_BITS;
   localparam int SB    = topkv_pkg::SCORE_BITS;

   // sequencer states
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_START = 2'd1;
   localparam logic [1:0] S_VOTE  = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   logic [1:0] state_ff, state_in;

   // configuration registers
   logic signed [SB-1:0]                 thr_ff, thr_in;
   logic [topkv_pkg::NCOUNT_BITS-1:0]    ncount_ff, ncount_in;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   topkv_pkg::rsp_item_type    rsp_item_ff, rsp_item_in;
   logic                       found_ff, found_in;

   logic                       accept;
   logic                       load_rsp;
   logic                       tally_clear, tally_step;
   topkv_pkg::cell_ctl_type    ctl;

   // clamped number of voters
   logic [topkv_pkg::NCOUNT_BITS-1:0] ncount_eff;
   logic [LIM_W-1:0]                  ncount_ext;
   logic [CNT_W-1:0]                  vote_limit;

   // chain wiring
   logic [MAX_NEIGHBOURS-1:0] take_w, valid_w, member_w, pending_w;
   logic [IDENTITY_BITS-1:0]  id_w [MAX_NEIGHBOURS];
   logic signed [SB-1:0]      score_w [MAX_NEIGHBOURS];
   logic [IDENTITY_BITS-1:0]  new_id;

   logic [IDENTITY_BITS-1:0]  best_id;
   logic [CNT_W-1:0]          best_votes;
   logic [LIM_W-1:0]          best_votes_ext;

   // ---------------------------------------------------------------- config
   always_comb begin
      thr_in    = thr_ff;
      ncount_in = ncount_ff;
      if (csr_write) begin
         unique case (csr_index)
            topkv_pkg::CSR_THRESHOLD:  thr_in    = csr_wdata;
            topkv_pkg::CSR_NEIGHBOURS: ncount_in = csr_wdata[topkv_pkg::NCOUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // zero counts as one, above the chain length saturates
   assign ncount_eff = (ncount_ff == '0) ? topkv_pkg::NCOUNT_BITS'(1) : ncount_ff;
   assign ncount_ext = LIM_W'(ncount_eff);
   assign vote_limit = (ncount_ext > LIM_W'(MAX_NEIGHBOURS)) ? CNT_W'(MAX_NEIGHBOURS)
                                                             : CNT_W'(ncount_ext);

   // ---------------------------------------------------------------- sequencer
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign new_id    = IDENTITY_BITS'(req_item.identity);

   // result register is free when empty or being taken this cycle
   assign load_rsp  = (state_ff == S_EMIT) & (~rsp_valid_ff | ~rsp_stall);

   always_comb begin
      state_in    = state_ff;
      found_in    = found_ff;
      ctl         = '0;
      tally_clear = 1'b0;
      tally_step  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            ctl.insert = accept;
            if (accept && req_item.final_item) begin
               state_in = S_START;
            end
         end
         S_START: begin
            // head of the chain holds the best score
            ctl.start   = 1'b1;
            tally_clear = 1'b1;
            found_in    = valid_w[0] & (score_w[0] > thr_ff);
            state_in    = found_in ? S_VOTE : S_EMIT;
         end
         S_VOTE: begin
            // head entry is the candidate; chain rotates toward the head
            if (pending_w[0]) begin
               tally_step = 1'b1;
               ctl.rotate = 1'b1;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (load_rsp) begin
               ctl.clear = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- cell chain
   for (genvar i = 0; i < MAX_NEIGHBOURS; i++) begin : g_cell
      logic                      p_take, p_valid, n_valid, n_member, n_pending;
      logic [IDENTITY_BITS-1:0]  p_id, n_id;
      logic signed [SB-1:0]      p_score, n_score;

      if (i == 0) begin : g_head
         assign p_take  = 1'b0;
         assign p_valid = 1'b0;
         assign p_id    = '0;
         assign p_score = '0;
      end else begin : g_body
         assign p_take  = take_w[i-1];
         assign p_valid = valid_w[i-1];
         assign p_id    = id_w[i-1];
         assign p_score = score_w[i-1];
      end

      if (i == MAX_NEIGHBOURS - 1) begin : g_tail
         // the head wraps to the tail with its candidate mark dropped
         assign n_valid   = valid_w[0];
         assign n_id      = id_w[0];
         assign n_score   = score_w[0];
         assign n_member  = member_w[0];
         assign n_pending = 1'b0;
      end else begin : g_link
         assign n_valid   = valid_w[i+1];
         assign n_id      = id_w[i+1];
         assign n_score   = score_w[i+1];
         assign n_member  = member_w[i+1];
         assign n_pending = pending_w[i+1];
      end

      topkv_cell #(
         .INDEX (i),
         .ID_W  (IDENTITY_BITS),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .vote_limit   (vote_limit),
         .new_id       (new_id),
         .new_score    (req_item.score),
         .prev_take    (p_take),
         .prev_valid   (p_valid),
         .prev_id      (p_id),
         .prev_score   (p_score),
         .next_valid   (n_valid),
         .next_id      (n_id),
         .next_score   (n_score),
         .next_member  (n_member),
         .next_pending (n_pending),
         .take         (take_w[i]),
         .valid        (valid_w[i]),
         .id           (id_w[i]),
         .score        (score_w[i]),
         .member       (member_w[i]),
         .pending      (pending_w[i])
      );
   end

   // ---------------------------------------------------------------- vote
   topkv_tally #(
      .MAX_NEIGHBOURS (MAX_NEIGHBOURS),
      .ID_W           (IDENTITY_BITS),
      .CNT_W          (CNT_W)
   ) u_tally (
      .clock      (clock),
      .clear      (tally_clear),
      .step       (tally_step),
      .cand_id    (id_w[0]),
      .member     (member_w),
      .ids        (id_w),
      .best_id    (best_id),
      .best_votes (best_votes)
   );

   // ---------------------------------------------------------------- result
   assign best_votes_ext = LIM_W'(best_votes);

   always_comb begin
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (load_rsp) begin
         rsp_valid_in        = 1'b1;
         rsp_item_in.found   = found_ff;
         rsp_item_in.winner  = found_ff ? topkv_pkg::FIELD_ID_BITS'(best_id) : '0;
         // ballots saturate at the field maximum
         if (!found_ff) begin
            rsp_item_in.ballots = '0;
         end else if (best_votes_ext > LIM_W'({topkv_pkg::BALLOT_BITS{1'b1}})) begin
            rsp_item_in.ballots = '1;
         end else begin
            rsp_item_in.ballots = topkv_pkg::BALLOT_BITS'(best_votes_ext);
         end
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thr_ff       <= topkv_pkg::THRESHOLD_RESET;
         ncount_ff    <= topkv_pkg::NEIGHBOUR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         ncount_ff    <= ncount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      found_ff    <= found_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef NO_ASSERTIONS
   // kept entries form a prefix of the chain while items are taken in
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ((valid_w & (valid_w + MAX_NEIGHBOURS'(1))) == '0))
      else $error("kept entries are not contiguous from the head");

   // a candidate awaiting its count is always a voter
   a_pending_member: assert property (@(posedge clock) disable iff (reset)
      (pending_w & ~member_w) == '0)
      else $error("candidate entry outside the voter set");

   // a new result only comes out of the emit step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == S_EMIT))
      else $error("result raised outside the emit step");

   // a found result carries at least one ballot
   a_found_ballots: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.found) |-> (rsp_item_ff.ballots != '0))
      else $error("found result without ballots");

   // the chain is empty once a result is loaded into the result register
   a_cleared: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (valid_w == '0))
      else $error("chain not emptied after a search");
`endif

endmodule
`default_nettype wire

[dv/topk_similarity_vote_checker.sv]
// checker: ranks scores of each search, predicts the vote and compares result items
`timescale 1ns / 100ps
module topk_similarity_vote_checker #(
   parameter int RANK_DEPTH = topkv_pkg::MAX_NEIGHBOURS_DEF,
   parameter int ID_BITS    = topkv_pkg::IDENTITY_BITS_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   input  wire                                 req_stall,
   input  topkv_pkg::req_item_type             req_item,
   input  wire                                 rsp_valid,
   input  wire                                 rsp_stall,
   input  topkv_pkg::rsp_item_type             rsp_item,
   input  wire                                 csr_write,
   input  wire [topkv_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire [topkv_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                  failures,
   output int                                  pending,
   output int                                  results_seen,
   output int                                  predicted_found
);
   import topkv_pkg::*;

   localparam logic [FIELD_ID_BITS-1:0] ID_MASK = {FIELD_ID_BITS{1'b1}} >> (FIELD_ID_BITS - ID_BITS);
   localparam int BALLOT_MAX = (1 << BALLOT_BITS) - 1;

   // ranked list, best score first
   logic [FIELD_ID_BITS-1:0]     rank_id    [RANK_DEPTH];
   logic signed [SCORE_BITS-1:0] rank_score [RANK_DEPTH];
   int                           rank_fill;
   logic signed [SCORE_BITS-1:0] threshold;
   logic [NCOUNT_BITS-1:0]       neighbours;
   rsp_item_type                 expected_votes [$];
   rsp_item_type                 want;

   function automatic void rank_insert(input logic [FIELD_ID_BITS-1:0] id,
                                       input logic signed [SCORE_BITS-1:0] score);
      int slot;
      int tail;
      int i;
      slot = 0;
      // equal scores stay ahead of the newcomer
      while (slot < rank_fill && rank_score[slot] >= score) slot++;
      if (slot >= RANK_DEPTH) return;
      tail = (rank_fill < RANK_DEPTH) ? rank_fill : RANK_DEPTH - 1;
      for (i = tail; i > slot; i--) begin
         rank_id[i]    = rank_id[i-1];
         rank_score[i] = rank_score[i-1];
      end
      rank_id[slot]    = id;
      rank_score[slot] = score;
      if (rank_fill < RANK_DEPTH) rank_fill++;
   endfunction

   function automatic rsp_item_type tally_vote();
      rsp_item_type             verdict;
      int                       voters;
      int                       votes;
      int                       best_votes;
      int                       i;
      int                       j;
      logic [FIELD_ID_BITS-1:0] best_id;
      verdict    = '0;
      best_votes = 0;
      best_id    = '0;
      if (rank_fill > 0 && rank_score[0] > threshold) begin
         voters = (neighbours == 0) ? 1 : int'(neighbours);
         if (voters > RANK_DEPTH) voters = RANK_DEPTH;
         if (voters > rank_fill) voters = rank_fill;
         for (i = 0; i < voters; i++) begin
            votes = 0;
            for (j = 0; j < voters; j++)
               if (rank_id[j] == rank_id[i]) votes++;
            // strict compare: first identity in score order wins a tie
            if (votes > best_votes) begin
               best_votes = votes;
               best_id    = rank_id[i];
            end
         end
         if (best_votes > BALLOT_MAX) best_votes = BALLOT_MAX;
         verdict.found   = 1'b1;
         verdict.winner  = best_id;
         verdict.ballots = best_votes[BALLOT_BITS-1:0];
      end
      return verdict;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      failures++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rank_fill  = 0;
         threshold  = THRESHOLD_RESET;
         neighbours = NEIGHBOUR_RESET;
         expected_votes.delete();
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            results_seen++;
            if (expected_votes.size() == 0) begin
               report_mismatch($sformatf("result with none expected: found=%b winner=%h ballots=%0d",
                                         rsp_item.found, rsp_item.winner, rsp_item.ballots));
            end else begin
               want = expected_votes.pop_front();
               if (rsp_item.found !== want.found)
                  report_mismatch($sformatf("found %b, expected %b", rsp_item.found, want.found));
               if (rsp_item.winner !== want.winner)
                  report_mismatch($sformatf("winner %h, expected %h", rsp_item.winner, want.winner));
               if (rsp_item.ballots !== want.ballots)
                  report_mismatch($sformatf("ballots %0d, expected %0d",
                                            rsp_item.ballots, want.ballots));
            end
         end
         if (csr_write === 1'b1) begin
            case (csr_index)
               CSR_THRESHOLD:  threshold  = csr_wdata;
               CSR_NEIGHBOURS: neighbours = csr_wdata[NCOUNT_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            rank_insert(req_item.identity & ID_MASK, req_item.score);
            if (req_item.final_item) begin
               want = tally_vote();
               // queue the prediction behind the earlier ones
               expected_votes = {expected_votes, want};
               if (want.found) predicted_found++;
               rank_fill = 0;
            end
         end
      end
      pending = expected_votes.size();
   end

endmodule

[dv/testbench.sv]
// testbench top: clock, reset, stimulus and verdict for the top-k similarity vote block
`timescale 1ns / 100ps
module testbench;
   import topkv_pkg::*;

   localparam int CLOCK_PERIOD  = 10;
   localparam int RESET_CYCLES  = 7;
   // quiet time after the last result is taken, leave some margin
   localparam int SETTLE_CYCLES = 16;
   localparam int LONG_HOLD     = 400;
   localparam int RANDOM_ITEMS  = 1100;
   localparam int RUN_LIMIT_NS  = 5_000_000;

   // register indexes the block does not decode
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_B = 2'd3;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   req_item_type              req_item;
   logic                      rsp_valid;
   logic                      rsp_stall;
   rsp_item_type              rsp_item;
   logic                      csr_write;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   int failures;
   int pending;
   int results_seen;
   int predicted_found;

   // handshake seen at the last rising edge, read back at the falling edge
   bit req_taken;
   bit rsp_taken;

   // pacing knobs for sender and receiver, changed per phase
   int  gap_max   = 16;
   int  stall_max = 16;
   bit  long_hold_go;
   int  items_sent;
   int  searches_sent;
   int  phase;
   logic signed [SCORE_BITS-1:0] cur_threshold;

   topk_similarity_vote_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   topk_similarity_vote_checker vote_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_item        (req_item),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_item        (rsp_item),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .failures        (failures),
      .pending         (pending),
      .results_seen    (results_seen),
      .predicted_found (predicted_found)
   );

   initial clock = 1'b0;
   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      req_taken <= !reset && req_valid && (req_stall === 1'b0);
      rsp_taken <= !reset && (rsp_valid === 1'b1) && !rsp_stall;
   end

   // offer one item after a random gap, hold it until the block takes it
   task automatic send_item(input logic [FIELD_ID_BITS-1:0] id,
                            input logic signed [SCORE_BITS-1:0] score,
                            input bit is_final);
      int gap;
      gap = $urandom_range(gap_max, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= '{identity: id, score: score, final_item: is_final};
      do @(negedge clock); while (!req_taken);
      items_sent++;
      if (is_final) searches_sent++;
   endtask

   // stop offering, wait for every predicted result, then let the vote unit go quiet
   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_write <= 1'b0;
      if (index == CSR_THRESHOLD) cur_threshold = data;
      @(negedge clock);
   endtask

   // new setting only once the block is idle; upper data bits of the count are junk
   task automatic set_config(input logic signed [SCORE_BITS-1:0] thr,
                             input logic [NCOUNT_BITS-1:0] k);
      drain();
      write_csr(CSR_THRESHOLD, thr);
      write_csr(CSR_NEIGHBOURS, {12'($urandom()), k});
   endtask

   // one well-formed search: a run of scores closed by a final item
   task automatic run_search(input int len);
      int                           i;
      logic [FIELD_ID_BITS-1:0]     id_base;
      logic [FIELD_ID_BITS-1:0]     id;
      logic signed [SCORE_BITS-1:0] score;
      id_base = 16'($urandom());
      for (i = 0; i < len; i++) begin
         // mostly a small pool of identities so that votes collide
         if ($urandom_range(9, 0) < 7) id = id_base + 16'($urandom_range(3, 0));
         else id = 16'($urandom());
         case ($urandom_range(3, 0))
            0: score = 16'($urandom());
            // just around the threshold, equality included
            1: score = cur_threshold - 16'sd4 + 16'($urandom_range(8, 0));
            2: begin
               case ($urandom_range(3, 0))
                  0: score = 16'sh7FFF;
                  1: score = 16'sh8000;
                  2: score = 16'sh0000;
                  default: score = 16'shFFFF;
               endcase
            end
            // a handful of values at or above the threshold, many ties
            default: score = cur_threshold + 16'($urandom_range(3, 0) * 256);
         endcase
         send_item(id, score, i == len - 1);
      end
   endtask

   // receiver: random stall after each result item, plus one long hold on request
   initial begin : receiver
      int pause;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_go) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            rsp_stall <= 1'b0;
            long_hold_go = 1'b0;
         end else if (rsp_taken) begin
            pause = $urandom_range(stall_max, 0);
            if (pause > 0) begin
               rsp_stall <= 1'b1;
               repeat (pause) @(negedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   initial begin : stimulus
      int random_start;
      int len;
      logic signed [SCORE_BITS-1:0] thr;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_item      = '0;
      csr_write     = 1'b0;
      csr_index     = CSR_THRESHOLD;
      csr_wdata     = '0;
      long_hold_go  = 1'b0;
      cur_threshold = THRESHOLD_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part, reset setting first: threshold 0.6, three voters
      send_item(16'hFFFF, 16'sh7FFF, 1'b0);
      send_item(16'h0000, 16'sh8000, 1'b0);
      send_item(16'hFFFF, 16'sd19662, 1'b0);
      send_item(16'h0001, 16'sd19661, 1'b1);
      // best score equal to the threshold is not enough
      send_item(16'h1234, 16'sd19661, 1'b1);
      send_item(16'h00AA, 16'sd19662, 1'b1);

      // lowest threshold, neighbour count zero votes as one
      set_config(16'sh8000, 4'd0);
      send_item(16'h0002, 16'sh8000, 1'b1);
      send_item(16'h0003, -16'sd32767, 1'b0);
      send_item(16'h0004, -16'sd32767, 1'b1);

      // equal scores keep arrival order, equal votes go to the first identity
      set_config(-16'sd100, 4'd2);
      send_item(16'h0005, 16'sd100, 1'b0);
      send_item(16'h0006, 16'sd100, 1'b0);
      send_item(16'h0005, 16'sd100, 1'b1);

      // count above the list depth saturates; a full list drops scores not above its tail
      set_config(16'sd0, 4'd15);
      send_item(16'h0007, 16'sd900, 1'b0);
      send_item(16'h0007, 16'sd800, 1'b0);
      send_item(16'h0008, 16'sd700, 1'b0);
      send_item(16'h0008, 16'sd600, 1'b0);
      send_item(16'h0008, 16'sd500, 1'b0);
      send_item(16'h0009, 16'sd400, 1'b0);
      send_item(16'h0009, 16'sd300, 1'b0);
      send_item(16'h0009, 16'sd200, 1'b0);
      send_item(16'h000A, 16'sd200, 1'b0);
      send_item(16'h000B, 16'sd100, 1'b1);

      // writes to undecoded indexes must leave both registers alone
      drain();
      write_csr(CSR_SPARE_A, 16'h0000);
      write_csr(CSR_SPARE_B, 16'hFFFF);

      // top threshold: nothing can be found
      set_config(16'sh7FFF, 4'd8);
      send_item(16'h5555, 16'sh7FFF, 1'b1);

      // fewer items than voters: only the kept ones vote
      set_config(THRESHOLD_RESET, 4'd5);
      send_item(16'hAAAA, 16'sd20000, 1'b0);
      send_item(16'hAAAA, 16'sd30000, 1'b1);

      // random part: one setting per phase, a batch of searches under it
      random_start = items_sent;
      phase = 0;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         phase++;
         case ($urandom_range(5, 0))
            0: thr = 16'sh8000;
            1: thr = 16'sh7FFF;
            2: thr = THRESHOLD_RESET;
            default: thr = 16'($urandom());
         endcase
         set_config(thr, 4'($urandom_range(15, 0)));
         if (phase == 3) begin
            // receiver sits still while the sender floods the block
            gap_max   = 0;
            stall_max = 16;
            long_hold_go = 1'b1;
         end else if (phase % 4 == 1) begin
            // back to back on both sides
            gap_max   = 0;
            stall_max = 0;
         end else begin
            gap_max   = 16;
            stall_max = 16;
         end
         repeat ($urandom_range(12, 4)) begin
            // mostly short searches, some that overflow the list
            if ($urandom_range(5, 0) == 0) len = $urandom_range(14, 9);
            else len = $urandom_range(8, 1);
            run_search(len);
         end
      end

      // every result in, then a quiet stretch for stray items
      drain();
      $display("covered %0d items in %0d searches over %0d random settings",
               items_sent, searches_sent, phase);
      $display("checked %0d results, %0d with a winner, %0d unknown",
               results_seen, predicted_found, results_seen - predicted_found);
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // hard stop for a hung handshake
   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("FAIL");
      $finish;
   end

endmodule

[topk_similarity_vote_top.f]
hw/rtl/topkv_pkg.sv
hw/rtl/topkv_cell.sv
hw/rtl/topkv_tally.sv
hw/rtl/topk_similarity_vote_top.sv
dv/topk_similarity_vote_checker.sv
dv/testbench.sv
